// ===== rtl/urlpd_pkg.sv =====
package urlpd_pkg;

  localparam logic [7:0] PLUS_CHAR    = 8'h2B;
  localparam logic [7:0] PERCENT_CHAR = 8'h25;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
  } out_item_t;

  // Bytes released by one input transfer, held until all have been sent.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  count;
    logic                        text_last;
  } group_t;

  // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 are its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, c[3:0]};
    end else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/urlpd_decode.sv =====
module urlpd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  urlpd_pkg::in_item_t item,
  output logic              grp_valid,
  output urlpd_pkg::group_t grp,
  input  logic              grp_free
);

  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_PERCENT = 2'd1;
  localparam logic [1:0] PHASE_DIGIT   = 2'd2;

  logic                 a_valid;
  urlpd_pkg::in_item_t  a_item;
  logic [1:0]           escape_phase;
  logic [1:0]           escape_phase_next;
  logic [7:0]           held_char;
  logic [7:0]           held_char_next;
  logic [1:0]           cnt;
  logic                 a_pop;
  logic [7:0]           b;
  logic [4:0]           b_hex;
  logic [4:0]           held_hex;

  assign b        = a_item.in_byte;
  assign b_hex    = urlpd_pkg::hex_nibble(b);
  assign held_hex = urlpd_pkg::hex_nibble(held_char);

  always_comb begin
    logic fresh;
    fresh             = 1'b0;
    cnt               = 2'd0;
    grp.bytes         = '0;
    escape_phase_next = PHASE_IDLE;
    held_char_next    = held_char;

    case (escape_phase)
      PHASE_PERCENT: begin
        if (!b_hex[4]) begin
          held_char_next    = b;
          escape_phase_next = PHASE_DIGIT;
        end else begin
          grp.bytes[cnt] = urlpd_pkg::PERCENT_CHAR;
          cnt            = cnt + 2'd1;
          fresh          = 1'b1;
        end
      end
      PHASE_DIGIT: begin
        if (!b_hex[4]) begin
          grp.bytes[cnt] = {held_hex[3:0], b_hex[3:0]};
          cnt            = cnt + 2'd1;
        end else begin
          grp.bytes[cnt] = urlpd_pkg::PERCENT_CHAR;
          cnt            = cnt + 2'd1;
          grp.bytes[cnt] = held_char;
          cnt            = cnt + 2'd1;
          fresh          = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // A byte decoded with no escape pending; it may open a new escape.
    if (fresh) begin
      if (b == urlpd_pkg::PLUS_CHAR) begin
        grp.bytes[cnt] = urlpd_pkg::SPACE_CHAR;
        cnt            = cnt + 2'd1;
      end else if (b == urlpd_pkg::PERCENT_CHAR) begin
        escape_phase_next = PHASE_PERCENT;
      end else begin
        grp.bytes[cnt] = b;
        cnt            = cnt + 2'd1;
      end
    end

    // At the end of the text any pending escape is flushed literally.
    if (a_item.in_last) begin
      if (escape_phase_next == PHASE_PERCENT) begin
        grp.bytes[cnt] = urlpd_pkg::PERCENT_CHAR;
        cnt            = cnt + 2'd1;
      end else if (escape_phase_next == PHASE_DIGIT) begin
        grp.bytes[cnt] = urlpd_pkg::PERCENT_CHAR;
        cnt            = cnt + 2'd1;
        grp.bytes[cnt] = held_char_next;
        cnt            = cnt + 2'd1;
      end
      escape_phase_next = PHASE_IDLE;
      held_char_next    = 8'h00;
    end

    grp.count     = cnt;
    grp.text_last = a_item.in_last;
  end

  assign grp_valid  = a_valid && (cnt != 2'd0);
  assign a_pop      = a_valid && ((cnt == 2'd0) || grp_free);
  assign item_ready = !a_valid || a_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      escape_phase <= PHASE_IDLE;
      held_char    <= 8'h00;
    end else begin
      if (item_ready) begin
        a_valid <= item_valid;
      end
      if (a_pop) begin
        escape_phase <= escape_phase_next;
        held_char    <= held_char_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      a_item <= item;
    end
  end

endmodule

// ===== rtl/urlpd_outbuf.sv =====
module urlpd_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                grp_valid,
  input  urlpd_pkg::group_t   grp,
  output logic                grp_free,
  output logic                result_valid,
  input  logic                result_ready,
  output urlpd_pkg::out_item_t result
);

  urlpd_pkg::group_t g;
  logic              g_valid;
  logic [1:0]        idx;
  logic              slot_last;

  assign slot_last    = (idx == g.count - 2'd1);
  assign grp_free     = !g_valid || (slot_last && result_ready);
  assign result_valid = g_valid;

  always_comb begin
    result.out_byte  = g.bytes[idx];
    result.run_last  = slot_last;
    result.text_last = slot_last && g.text_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      idx     <= 2'd0;
    end else if (grp_valid && grp_free) begin
      g_valid <= 1'b1;
      idx     <= 2'd0;
    end else if (g_valid && result_ready) begin
      if (slot_last) begin
        g_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_free) begin
      g <= grp;
    end
  end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// URL percent decoder, one encoded byte per input transfer.
// Input channel item_valid/item_ready carries item (in_byte, in_last); output
// channel result_valid/result_ready carries result (out_byte, run_last,
// text_last). A '+' becomes a space and "%XY" with two hex digits becomes one
// byte; a broken escape is passed through literally.
// An input byte is first captured in an input register, then decoded in one
// pass into a group of zero to three bytes that is loaded into the result
// register. The first byte of a group is offered from the result register,
// and result_valid then stays high until the group's last byte is taken.
// Throughput is one input byte per cycle while each byte yields at most one
// result and the receiver is ready; a longer group holds the result register
// until its last byte is taken and holds off further input. Bytes that yield
// no result (the start of an escape) pass the input register without waiting.
// Reset clears the pending escape and empties both registers; item_ready is
// high in the first cycle after reset. When the receiver stalls, the result
// register holds its byte, the input register fills, and item_ready drops.
module url_percent_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  urlpd_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output urlpd_pkg::out_item_t result
);

  logic              grp_valid;
  logic              grp_free;
  urlpd_pkg::group_t grp;

  urlpd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_free  (grp_free)
  );

  urlpd_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .grp_valid   (grp_valid),
    .grp         (grp),
    .grp_free    (grp_free),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ===== rtl/urlpd_checker.sv =====
module urlpd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input urlpd_pkg::in_item_t  item,
  input logic                 result_valid,
  input logic                 result_ready,
  input urlpd_pkg::out_item_t result
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered straight after reset");

  // An input transfer that is kept waiting keeps its payload.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("stalled input changed");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // The final byte of the text is always the last one of its input.
  a_text_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.text_last |-> result.run_last)
    else $error("text_last without run_last");

  // The bytes of one group follow each other without a gap.
  a_group_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.run_last |=> result_valid)
    else $error("gap inside a group of results");

endmodule

bind url_percent_decoder urlpd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .item        (item),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
